/* src/blkva_pkg.sv */
// ----------------------------------------------------------------------------
// blkva_pkg
// Shared types and constants of the blocking variance accumulator.
// ----------------------------------------------------------------------------
package blkva_pkg;

	localparam int OP_W     = 1;
	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 5;
	localparam int SUM_W    = 48;
	localparam int SQ_W     = 63;
	localparam int COUNT_W  = 32;

	localparam logic [OP_W-1:0] OP_ADD  = 1'b0;
	localparam logic [OP_W-1:0] OP_READ = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_WRITE,
		ST_RESULT
	} state_t;

endpackage

/* src/blkva_ram.sv */
// ----------------------------------------------------------------------------
// blkva_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module blkva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/blocking_variance_accumulator_core.sv */
// ----------------------------------------------------------------------------
// blocking_variance_accumulator_core
// Streaming reblocking accumulator for correlated samples.
// ----------------------------------------------------------------------------
// An add word takes one signed sample and walks the blocking levels held in a
// single memory, one level at a time: each completed level is read, squared
// and written back, and a final step folds the last block average into the
// pending sum of the next level. An add holds the block until its walk ends;
// at a full sample count, an add is accepted but only sets the full flag.
// A read word returns one level's sums with the sample count and full flag,
// and holds the block until its result is loaded into the output register.
// Entries read as zero until first written, so no clearing pass follows reset.
module blocking_variance_accumulator_core #(
	parameter int LEVELS      = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [blkva_pkg::OP_W-1:0]          op,
	input  logic signed [blkva_pkg::SAMPLE_W-1:0] sample,
	input  logic [blkva_pkg::LEVEL_W-1:0]       level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [blkva_pkg::LEVEL_W-1:0]       level_out,
	output logic signed [blkva_pkg::SUM_W-1:0]  sum,
	output logic [blkva_pkg::SQ_W-1:0]          sum_squares,
	output logic [blkva_pkg::COUNT_W-1:0]       count,
	output logic                                full_res
);
	import blkva_pkg::*;

	localparam int LW    = $clog2(LEVELS);
	localparam int PW    = SAMPLE_BITS + 1;
	localparam int RAW_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam int ENT_W = SUM_W + SQ_W + PW;
	localparam int PROD_W = 2 * SAMPLE_BITS;

	state_t state_q, state_d;

	logic [LW-1:0]                 idx_q;
	logic                          process_q;
	logic signed [SAMPLE_BITS-1:0] carry_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [COUNT_W-1:0]            count_q;
	logic                          saturated_q;
	logic [LEVELS-1:0]             valid_q;

	logic                          rd_valid_s1;
	logic                          rd_inrange_s1;
	logic [LEVEL_W-1:0]            rd_level_s1;
	logic signed [SAMPLE_BITS-1:0] v_s1;
	logic [SUM_W-1:0]              sum_s1;
	logic [SQ_W-1:0]               sq_s1;
	logic signed [PROD_W-1:0]      prod_s2;

	logic                          out_valid_q;
	logic [LEVEL_W-1:0]            level_out_q;
	logic [SUM_W-1:0]              sum_q;
	logic [SQ_W-1:0]               sq_q;
	logic [COUNT_W-1:0]            count_out_q;
	logic                          full_q;

	logic                          ram_we;
	logic [LW-1:0]                 ram_waddr;
	logic [ENT_W-1:0]              ram_wdata;
	logic                          ram_re;
	logic [LW-1:0]                 ram_raddr;
	logic [ENT_W-1:0]              ram_rdata;

	logic                          in_acc;
	logic                          in_range;
	logic [RAW_W-1:0]              raw;
	logic signed [SAMPLE_BITS-1:0] x_in;
	logic [SUM_W-1:0]              e_sum;
	logic [SQ_W-1:0]               e_sq;
	logic signed [PW-1:0]          e_pend;
	logic signed [PW-1:0]          pend_in;
	logic signed [PW-1:0]          half;
	logic signed [SAMPLE_BITS-1:0] v_ld;
	logic                          out_load;
	logic                          last_level;

	blkva_ram #(
		.WIDTH(ENT_W),
		.DEPTH(LEVELS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_acc   = in_valid && in_ready;
	assign in_range = {1'b0, level} < (LEVEL_W + 1)'(LEVELS);
	assign raw      = RAW_W'($unsigned(sample));
	assign x_in     = signed'(raw[SAMPLE_BITS-1:0]);

	assign e_sum  = rd_valid_s1 ? ram_rdata[ENT_W-1 -: SUM_W] : '0;
	assign e_sq   = rd_valid_s1 ? ram_rdata[SQ_W+PW-1 -: SQ_W] : '0;
	assign e_pend = rd_valid_s1 ? signed'(ram_rdata[PW-1:0]) : '0;

	assign pend_in    = e_pend + PW'(carry_q);
	assign half       = pend_in >>> 1;
	assign v_ld       = (idx_q == '0) ? x_q : half[SAMPLE_BITS-1:0];
	assign out_load   = !out_valid_q || out_ready;
	assign last_level = idx_q == LW'(LEVELS - 1);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {e_sum, e_sq, pend_in};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (op == OP_READ) begin
						ram_re    = 1'b1;
						ram_raddr = level[LW-1:0];
						state_d   = ST_RESULT;
					end else if (count_q != COUNT_MAX) begin
						ram_re    = 1'b1;
						ram_raddr = '0;
						state_d   = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				if (process_q) begin
					state_d = ST_MUL;
				end else begin
					ram_we  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = {sum_s1 + SUM_W'(v_s1),
					sq_s1 + SQ_W'($unsigned(prod_s2)), {PW{1'b0}}};
				if (last_level) begin
					state_d = ST_IDLE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_q + LW'(1);
					state_d   = ST_LOAD;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			saturated_q <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && op == OP_ADD) begin
				if (count_q == COUNT_MAX) begin
					saturated_q <= 1'b1;
				end else begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_RESULT && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_valid_s1 <= (state_q == ST_IDLE && op == OP_READ && !in_range) ? 1'b0
				: valid_q[ram_raddr];
		end
		if (in_acc) begin
			idx_q         <= '0;
			process_q     <= 1'b1;
			carry_q       <= '0;
			x_q           <= x_in;
			rd_inrange_s1 <= in_range;
			rd_level_s1   <= level;
		end
		if (state_q == ST_LOAD) begin
			v_s1   <= v_ld;
			sum_s1 <= e_sum;
			sq_s1  <= e_sq;
		end
		if (state_q == ST_MUL) begin
			prod_s2 <= v_s1 * v_s1;
		end
		if (state_q == ST_WRITE && !last_level) begin
			idx_q     <= idx_q + LW'(1);
			carry_q   <= v_s1;
			process_q <= !count_q[idx_q];
		end
		if (state_q == ST_RESULT && out_load) begin
			level_out_q <= rd_level_s1;
			sum_q       <= rd_inrange_s1 ? e_sum : '0;
			sq_q        <= rd_inrange_s1 ? e_sq : '0;
			count_out_q <= count_q;
			full_q      <= saturated_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign level_out   = level_out_q;
	assign sum         = signed'(sum_q);
	assign sum_squares = sq_q;
	assign count       = count_out_q;
	assign full_res    = full_q;

	// The memory is written back only while an add walks the levels.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && (state_q == ST_IDLE || state_q == ST_RESULT)))
		else $error("memory written outside an add");

	// The full flag never clears once set.
	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		saturated_q |=> saturated_q)
		else $error("full flag cleared");

	// The sample count advances by at most one per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> count_q == $past(count_q) + COUNT_W'(1))
		else $error("sample count jumped");

	// Every level load follows a read issued in the cycle before.
	a_load_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> $past(ram_re))
		else $error("level loaded without a read");

	// Count changes only while idle, so a reported count never lags an add.
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q) == ST_IDLE)
		else $error("count changed during a walk");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the blocking variance accumulator core.
// ----------------------------------------------------------------------------
// Add and read words go in through a bursty sender. A software copy of the
// reblocking arithmetic follows every accepted word. Each read queues the
// level report it should return, and a checker compares every returned word
// field by field. The receiver stalls on shifting patterns, and once it holds
// off long enough for the core to back up and stall its input.
module tb;
	import blkva_pkg::*;

	localparam int LEVELS       = 32;
	localparam int SAMPLE_BITS  = 16;
	localparam int RANDOM_ITEMS = 1580;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct {
		logic [LEVEL_W-1:0] lvl;
		logic [SUM_W-1:0]   s;
		logic [SQ_W-1:0]    sq;
		logic [COUNT_W-1:0] n;
		logic               full;
	} level_report_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     op          = OP_ADD;
	sample_t             sample      = '0;
	logic [LEVEL_W-1:0]  level       = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [LEVEL_W-1:0]  level_out;
	logic signed [SUM_W-1:0] sum;
	logic [SQ_W-1:0]     sum_squares;
	logic [COUNT_W-1:0]  count;
	logic                full_res;

	bit [SUM_W-1:0]      acc_sum [LEVELS];
	bit [SQ_W-1:0]       acc_sq [LEVELS];
	longint              pair_sum [LEVELS];
	bit [COUNT_W-1:0]    samples_seen;
	bit                  dropped;

	level_report_t       expected_reports[$];
	int                  err_count;
	int                  cycle_count;
	int                  burst_left;
	bit                  steady_sender;
	bit                  hold_req;

	blocking_variance_accumulator_core #(
		.LEVELS(LEVELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.sample(sample),
		.level(level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level_out(level_out),
		.sum(sum),
		.sum_squares(sum_squares),
		.count(count),
		.full_res(full_res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	function automatic void add_block(input int k, input longint v);
		longint sq;
		sq = v * v;
		acc_sum[k] = acc_sum[k] + v[SUM_W-1:0];
		acc_sq[k] = acc_sq[k] + sq[SQ_W-1:0];
	endfunction

	function automatic void fold_sample(input sample_t x);
		bit [COUNT_W-1:0] mask;
		longint avg;
		if (samples_seen == COUNT_MAX) begin
			dropped = 1'b1;
			return;
		end
		samples_seen++;
		add_block(0, longint'(x));
		pair_sum[1] += longint'(x);
		for (int k = 1; k < LEVELS; k++) begin
			mask = (32'd1 << k) - 32'd1;
			if ((samples_seen & mask) != 0)
				break;
			avg = pair_sum[k] >>> 1;
			add_block(k, avg);
			if (k + 1 < LEVELS)
				pair_sum[k + 1] += avg;
			pair_sum[k] = 0;
		end
	endfunction

	function automatic void snapshot_level(input logic [LEVEL_W-1:0] lv);
		level_report_t r;
		r.lvl  = lv;
		r.s    = (lv < LEVELS) ? acc_sum[lv] : '0;
		r.sq   = (lv < LEVELS) ? acc_sq[lv] : '0;
		r.n    = samples_seen;
		r.full = dropped;
		expected_reports.push_back(r);
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (err_count < 100)
			$display("mismatch %s at %0t: got %h want %h", field, $realtime, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin : check_words
		level_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch("unexpected word", {59'd0, level_out}, '0);
			end else begin
				want = expected_reports.pop_front();
				if (level_out !== want.lvl)
					report_mismatch("level_out", {59'd0, level_out}, {59'd0, want.lvl});
				if (sum !== want.s)
					report_mismatch("sum", {16'd0, sum}, {16'd0, want.s});
				if (sum_squares !== want.sq)
					report_mismatch("sum_squares", {1'b0, sum_squares}, {1'b0, want.sq});
				if (count !== want.n)
					report_mismatch("count", {32'd0, count}, {32'd0, want.n});
				if (full_res !== want.full)
					report_mismatch("full_res", {63'd0, full_res}, {63'd0, want.full});
			end
		end
	end

	initial begin : receiver
		int mode;
		int left;
		logic [7:0] pattern;
		left = 0;
		mode = 0;
		pattern = 8'hff;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(8, 80);
				pattern = 8'($urandom);
			end
			left--;
			case (mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					out_ready <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					out_ready <= pattern[left % 8];
				end
			endcase
		end
	end

	task automatic send_word(input logic [OP_W-1:0] w_op, input sample_t w_sample,
			input logic [LEVEL_W-1:0] w_level);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (steady_sender)
				gap = 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= w_op;
		sample <= w_sample;
		level <= w_level;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (w_op == OP_ADD)
			fold_sample(w_sample);
		else
			snapshot_level(w_level);
	endtask

	function automatic sample_t draw_sample(input int style, input sample_t fixed);
		case (style)
			0: return sample_t'($urandom);
			1: return sample_t'(int'($urandom_range(0, 15)) - 8);
			2: return ($urandom_range(0, 1) == 0) ? sample_t'(32767) : sample_t'(-32768);
			3: return fixed;
			default: return sample_t'(-(2 * int'($urandom_range(0, 100)) + 1));
		endcase
	endfunction

	task automatic test_empty_reads();
		send_word(OP_READ, '0, 5'd0);
		send_word(OP_READ, '1, 5'd31);
	endtask

	task automatic test_extremes();
		sample_t vals [12];
		vals = '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd1, 16'sd0,
			-16'sd3, 16'sd0, 16'sd1, -16'sd32768, 16'sd32767, 16'sd0};
		foreach (vals[i])
			send_word(OP_ADD, vals[i], 5'd0);
		for (int lv = 0; lv < 5; lv++)
			send_word(OP_READ, '0, LEVEL_W'(lv));
		send_word(OP_READ, '0, 5'd31);
	endtask

	task automatic test_random_blocks();
		int sent;
		int j;
		int style;
		sample_t fixed;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				j = $urandom_range(1, 6);
				style = $urandom_range(0, 4);
				fixed = sample_t'($urandom);
				for (int i = 0; i < (1 << j); i++) begin
					send_word(OP_ADD, draw_sample(style, fixed), LEVEL_W'($urandom));
					sent++;
				end
				repeat ($urandom_range(1, 3)) begin
					send_word(OP_READ, sample_t'($urandom), LEVEL_W'($urandom_range(0, j + 2)));
					sent++;
				end
			end else begin
				repeat ($urandom_range(4, 16)) begin
					if ($urandom_range(0, 2) == 0)
						send_word(OP_READ, sample_t'($urandom), LEVEL_W'($urandom));
					else
						send_word(OP_ADD, sample_t'($urandom), LEVEL_W'($urandom));
					sent++;
				end
			end
		end
	endtask

	task automatic test_backpressure();
		steady_sender = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 48; i++) begin
			if (i % 4 == 3)
				send_word(OP_ADD, sample_t'($urandom), '0);
			else
				send_word(OP_READ, '0, LEVEL_W'(i % 8));
		end
		steady_sender = 1'b0;
	endtask

	initial begin
		err_count = 0;
		cycle_count = 0;
		burst_left = 0;
		steady_sender = 1'b0;
		hold_req = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_reads();
		test_extremes();
		test_random_blocks();
		test_backpressure();
		send_word(OP_READ, '0, 5'd0);
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

/* blocking_variance_accumulator_core.f */
src/blkva_pkg.sv
src/blkva_ram.sv
src/blocking_variance_accumulator_core.sv
dv/tb.sv
